[rtl/core/psieve_pkg.sv]
// Package for the prime sieve engine: field widths, microcode codes and the control store.
`timescale 1ns / 1ps

package psieve_pkg;

    localparam int W_VAL  = 9;
    localparam int W_PC   = 4;
    localparam int W_COND = 4;

    // Step addresses of the microprogram.
    localparam logic [W_PC-1:0] S_IDLE   = 4'd0;
    localparam logic [W_PC-1:0] S_INIT   = 4'd1;
    localparam logic [W_PC-1:0] S_OSTART = 4'd2;
    localparam logic [W_PC-1:0] S_OTEST  = 4'd3;
    localparam logic [W_PC-1:0] S_OCHK   = 4'd4;
    localparam logic [W_PC-1:0] S_MARK   = 4'd5;
    localparam logic [W_PC-1:0] S_ONEXT  = 4'd6;
    localparam logic [W_PC-1:0] S_SSTART = 4'd7;
    localparam logic [W_PC-1:0] S_SREAD  = 4'd8;
    localparam logic [W_PC-1:0] S_SCHK   = 4'd9;
    localparam logic [W_PC-1:0] S_SNEXT  = 4'd10;
    localparam logic [W_PC-1:0] S_FINAL  = 4'd11;

    // Condition selects.
    localparam logic [W_COND-1:0] C_NEVER      = 4'd0;
    localparam logic [W_COND-1:0] C_ALWAYS     = 4'd1;
    localparam logic [W_COND-1:0] C_NO_START   = 4'd2;
    localparam logic [W_COND-1:0] C_I_NE_N     = 4'd3;
    localparam logic [W_COND-1:0] C_SQ_GT_N    = 4'd4;
    localparam logic [W_COND-1:0] C_NOT_MARK   = 4'd5;
    localparam logic [W_COND-1:0] C_JI_LE_N    = 4'd6;
    localparam logic [W_COND-1:0] C_SCAN_STALL = 4'd7;
    localparam logic [W_COND-1:0] C_OUT_BUSY   = 4'd8;

    // Operations on the loop index i.
    localparam logic [1:0] I_KEEP = 2'd0;
    localparam logic [1:0] I_ZERO = 2'd1;
    localparam logic [1:0] I_TWO  = 2'd2;
    localparam logic [1:0] I_INC  = 2'd3;

    // Operations on the multiple pointer j.
    localparam logic [1:0] J_KEEP = 2'd0;
    localparam logic [1:0] J_SQ   = 2'd1;
    localparam logic [1:0] J_ADD  = 2'd2;

    // One control word. A wait step stays put while its condition holds and
    // then goes to the target; any other step jumps when its condition holds.
    typedef struct packed {
        logic [W_COND-1:0] cond;
        logic [W_PC-1:0]   target;
        logic              wait_step;
        logic              idle;
        logic              load_n;
        logic [1:0]        i_op;
        logic [1:0]        j_op;
        logic              mem_we;
        logic              mem_wd;
        logic              addr_j;
        logic              mem_rd;
        logic              clr_have;
        logic              scan;
        logic              emit_last;
    } t_ctrl;

    // Datapath status seen by the sequencer.
    typedef struct packed {
        logic start;
        logic i_ne_n;
        logic sq_gt_n;
        logic marked;
        logic ji_le_n;
        logic have;
        logic out_free;
    } t_flags;

    function automatic t_ctrl f_ucode(input logic [W_PC-1:0] pc);
        t_ctrl w;
        w = '0;
        case (pc)
            S_IDLE: begin
                w.cond = C_NO_START; w.target = S_INIT; w.wait_step = 1'b1;
                w.idle = 1'b1; w.load_n = 1'b1; w.i_op = I_ZERO;
            end
            S_INIT: begin
                w.cond = C_I_NE_N; w.target = S_INIT; w.mem_we = 1'b1;
                w.mem_wd = 1'b1; w.i_op = I_INC;
            end
            S_OSTART: begin
                w.i_op = I_TWO;
            end
            S_OTEST: begin
                w.cond = C_SQ_GT_N; w.target = S_SSTART; w.mem_rd = 1'b1;
            end
            S_OCHK: begin
                w.cond = C_NOT_MARK; w.target = S_ONEXT; w.j_op = J_SQ;
            end
            S_MARK: begin
                w.cond = C_JI_LE_N; w.target = S_MARK; w.mem_we = 1'b1;
                w.addr_j = 1'b1; w.j_op = J_ADD;
            end
            S_ONEXT: begin
                w.cond = C_ALWAYS; w.target = S_OTEST; w.i_op = I_INC;
            end
            S_SSTART: begin
                w.i_op = I_TWO; w.clr_have = 1'b1;
            end
            S_SREAD: begin
                w.mem_rd = 1'b1;
            end
            S_SCHK: begin
                w.cond = C_SCAN_STALL; w.target = S_SNEXT; w.wait_step = 1'b1;
                w.scan = 1'b1;
            end
            S_SNEXT: begin
                w.cond = C_I_NE_N; w.target = S_SREAD; w.i_op = I_INC;
            end
            S_FINAL: begin
                w.cond = C_OUT_BUSY; w.target = S_IDLE; w.wait_step = 1'b1;
                w.emit_last = 1'b1;
            end
            default: begin
                w.cond = C_ALWAYS; w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

[rtl/core/prime_sieve_engine_unit.sv]
// Top level of the prime sieve engine: datapath, bitmap memory and stream ports.
// Flow: the block takes the limit, sets the bitmap for entries 0..n, clears the
// multiples of each unmarked outer index, then scans entries 2..n for primes.
// Only one limit is in work at a time, as a new one is taken only in the idle step;
// the pace is set by the single-port bitmap and the three-step read loop of the scan.
// Reset clears the step counter, the held-prime flag and the output valid flag only.
`timescale 1ns / 1ps

module prime_sieve_engine_unit
    import psieve_pkg::*;
#(
    parameter int MAX_N = 256
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [8:0] limit, [15:9] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [8:0] prime_value, [15:9] zero
    output logic        m_axis_tlast   // last_prime
);

    localparam int              DEPTH = MAX_N + 1;
    localparam int              AW    = $clog2(DEPTH);
    localparam logic [W_VAL-1:0] C_MAX = W_VAL'(MAX_N);
    localparam logic [W_VAL-1:0] C_TWO = W_VAL'(2);

    t_ctrl  w_ctrl;
    logic   w_act;
    t_flags w_flags;

    // Datapath registers.
    logic [W_VAL-1:0] r_n;
    logic [W_VAL-1:0] r_i;
    logic [W_VAL-1:0] r_j;
    logic [W_VAL-1:0] r_pend;
    logic             r_have;
    logic             r_rd;

    // Output register, which lets the scan run on while a word waits.
    logic             r_ov;
    logic [W_VAL-1:0] r_oval;
    logic             r_olast;

    // The bitmap: one bit per candidate value.
    logic             r_mem [DEPTH];

    logic [W_VAL-1:0]   w_lim;
    logic [2*W_VAL-1:0] w_sq;
    logic [W_VAL:0]     w_ji;
    logic [W_VAL-1:0]   w_addr_full;
    logic [AW-1:0]      w_addr;
    logic               w_out_free;
    logic               w_emit_pend;
    logic               w_emit_last;

    psieve_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctrl  (w_ctrl),
        .o_act   (w_act)
    );

    // A limit beyond the bitmap is clamped to its top entry.
    assign w_lim = (s_axis_tdata[W_VAL-1:0] > C_MAX) ? C_MAX : s_axis_tdata[W_VAL-1:0];

    assign w_sq        = r_i * r_i;
    assign w_ji        = {1'b0, r_j} + {1'b0, r_i};
    assign w_addr_full = w_ctrl.addr_j ? r_j : r_i;
    assign w_addr      = w_addr_full[AW-1:0];
    assign w_out_free  = !r_ov || m_axis_tready;

    // A prime is held back until the scan knows whether another follows,
    // so that only the largest one goes out flagged as the last.
    assign w_emit_pend = w_act && w_ctrl.scan && r_rd && r_have;
    assign w_emit_last = w_act && w_ctrl.emit_last;

    always_comb begin
        w_flags.start    = s_axis_tvalid && (s_axis_tdata[W_VAL-1:0] >= C_TWO);
        w_flags.i_ne_n   = (r_i != r_n);
        w_flags.sq_gt_n  = (w_sq > {{W_VAL{1'b0}}, r_n});
        w_flags.marked   = r_rd;
        w_flags.ji_le_n  = (w_ji <= {1'b0, r_n});
        w_flags.have     = r_have;
        w_flags.out_free = w_out_free;
    end

    assign s_axis_tready = w_ctrl.idle;

    always_ff @(posedge i_clk) begin
        if (w_act && w_ctrl.mem_we) begin
            r_mem[w_addr] <= w_ctrl.mem_wd;
        end
        if (w_act && w_ctrl.mem_rd) begin
            r_rd <= r_mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_act) begin
            if (w_ctrl.load_n) begin
                r_n <= w_lim;
            end
            case (w_ctrl.i_op)
                I_ZERO:  r_i <= '0;
                I_TWO:   r_i <= C_TWO;
                I_INC:   r_i <= r_i + 1'b1;
                default: r_i <= r_i;
            endcase
            case (w_ctrl.j_op)
                J_SQ:    r_j <= w_sq[W_VAL-1:0];
                J_ADD:   r_j <= w_ji[W_VAL-1:0];
                default: r_j <= r_j;
            endcase
            if (w_ctrl.scan && r_rd) begin
                r_pend <= r_i;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (w_act && w_ctrl.clr_have) begin
            r_have <= 1'b0;
        end else if (w_act && w_ctrl.scan && r_rd) begin
            r_have <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_emit_pend || w_emit_last) begin
            r_ov <= 1'b1;
        end else if (m_axis_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit_pend || w_emit_last) begin
            r_oval  <= r_pend;
            r_olast <= w_emit_last;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {{(16 - W_VAL){1'b0}}, r_oval};
    assign m_axis_tlast  = r_olast;

`ifndef NO_ASSERTIONS
    // Every bitmap write stays within the current limit.
    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_act && w_ctrl.mem_we) |-> (w_addr_full <= r_n))
        else $error("bitmap write beyond the limit");

    // A word is only loaded when the output register is free to take it.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit_pend || w_emit_last) |-> w_out_free)
        else $error("output word overwritten before it was taken");

    // The closing word always carries a prime that the scan has found.
    a_last_has_prime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit_last |-> (r_have && (r_pend >= C_TWO) && (r_pend <= r_n)))
        else $error("last word without a held prime");

    // Primes leave in strictly ascending order.
    a_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit_pend |-> (r_i > r_pend))
        else $error("prime emitted out of order");
`endif

endmodule

[rtl/core/psieve_seq.sv]
// Microcode sequencer of the prime sieve engine: step counter, control store and jump logic.
`timescale 1ns / 1ps

module psieve_seq
    import psieve_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_flags i_flags,
    output t_ctrl  o_ctrl,
    output logic   o_act
);

    logic [W_PC-1:0] r_pc;
    logic [W_PC-1:0] n_pc;
    t_ctrl           w_ctrl;
    logic            w_cond;

    assign w_ctrl = f_ucode(r_pc);

    always_comb begin
        case (w_ctrl.cond)
            C_NEVER:      w_cond = 1'b0;
            C_ALWAYS:     w_cond = 1'b1;
            C_NO_START:   w_cond = !i_flags.start;
            C_I_NE_N:     w_cond = i_flags.i_ne_n;
            C_SQ_GT_N:    w_cond = i_flags.sq_gt_n;
            C_NOT_MARK:   w_cond = !i_flags.marked;
            C_JI_LE_N:    w_cond = i_flags.ji_le_n;
            C_SCAN_STALL: w_cond = i_flags.marked && i_flags.have && !i_flags.out_free;
            C_OUT_BUSY:   w_cond = !i_flags.out_free;
            default:      w_cond = 1'b0;
        endcase
    end

    always_comb begin
        if (w_ctrl.wait_step) begin
            n_pc = w_cond ? r_pc : w_ctrl.target;
        end else begin
            n_pc = w_cond ? w_ctrl.target : r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl = w_ctrl;
    // A wait step that is still waiting performs none of its actions.
    assign o_act  = !(w_ctrl.wait_step && w_cond);

endmodule

[tb/prime_stream_checker.sv]
// Checker for the prime sieve engine: predicts the primes for each limit word and compares them.
`timescale 1ns / 1ps

module prime_stream_checker
    import psieve_pkg::*;
#(
    parameter int MAX_N = 256
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_limit_valid,
    input  logic        i_limit_ready,
    input  logic [15:0] i_limit_data,   // [8:0] limit, [15:9] zero
    input  logic        i_prime_valid,
    input  logic        i_prime_ready,
    input  logic [15:0] i_prime_data,   // [8:0] prime_value, [15:9] zero
    input  logic        i_prime_last,   // last_prime
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [W_VAL-1:0] value;
        logic             last;
    } t_prime_word;

    t_prime_word expected_primes[$];
    int          fails = 0;

    // Runs the sieve up to the saturated limit and queues every prime found,
    // the largest one flagged as the last of its run.
    function automatic void queue_primes_upto(input logic [W_VAL-1:0] limit);
        bit is_prime [0:MAX_N];
        int n;
        int i;
        int j;
        int top_prime;
        n = limit;
        if (n > MAX_N)
            n = MAX_N;
        if (n < 2)
            return;
        for (i = 0; i <= n; i++)
            is_prime[i] = 1'b1;
        for (i = 2; i * i <= n; i++) begin
            if (is_prime[i]) begin
                for (j = i * i; j <= n; j += i)
                    is_prime[j] = 1'b0;
            end
        end
        top_prime = n;
        while (!is_prime[top_prime])
            top_prime--;
        for (i = 2; i <= n; i++) begin
            if (is_prime[i])
                expected_primes.push_back(
                    t_prime_word'{value: W_VAL'(i), last: (i == top_prime)});
        end
    endfunction

    always @(posedge i_clk) begin
        t_prime_word want;
        if (i_rst_n) begin
            if (i_prime_valid && i_prime_ready) begin
                if (expected_primes.size() == 0) begin
                    $display("%0t: unexpected prime word: expected none, actual value %0d last %0b",
                             $time, i_prime_data[W_VAL-1:0], i_prime_last);
                    fails++;
                end else begin
                    want = expected_primes.pop_front();
                    if (i_prime_data[W_VAL-1:0] !== want.value) begin
                        $display("%0t: prime value mismatch: expected %0d, actual %0d",
                                 $time, want.value, i_prime_data[W_VAL-1:0]);
                        fails++;
                    end
                    if (i_prime_last !== want.last) begin
                        $display("%0t: last flag mismatch on %0d: expected %0b, actual %0b",
                                 $time, want.value, want.last, i_prime_last);
                        fails++;
                    end
                    if (i_prime_data[15:W_VAL] !== '0) begin
                        $display("%0t: padding bits mismatch: expected 0, actual %0h",
                                 $time, i_prime_data[15:W_VAL]);
                        fails++;
                    end
                end
            end
            if (i_limit_valid && i_limit_ready)
                queue_primes_upto(i_limit_data[W_VAL-1:0]);
        end
        o_fail_count <= fails;
        o_pending    <= expected_primes.size();
    end

endmodule

[tb/tb.sv]
// Top of the prime sieve engine testbench: clock, reset, limit stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb
    import psieve_pkg::*;
();

    // The slowest legal run is about 230 limits, each with up to 54 primes that may
    // wait out a long stall; the limit below allows for several times that.
    localparam int CYCLE_LIMIT  = 4_000_000;
    // A limit word below two gives no primes, so the block may still be busy
    // when the last prime has arrived. This covers a full pass at the largest
    // limit with room to spare.
    localparam int DRAIN_CYCLES = 1500;
    localparam int RANDOM_WORDS = 200;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;  // [8:0] limit, [15:9] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // [8:0] prime_value, [15:9] zero
    logic        m_axis_tlast;        // last_prime

    int fail_count;
    int pending_primes;
    int cycles     = 0;
    int rx_hold    = 0;
    // When set, the matching side runs without any gaps.
    bit tx_steady  = 1'b0;
    bit rx_steady  = 1'b0;

    prime_sieve_engine_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    prime_stream_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_limit_valid (s_axis_tvalid),
        .i_limit_ready (s_axis_tready),
        .i_limit_data  (s_axis_tdata),
        .i_prime_valid (m_axis_tvalid),
        .i_prime_ready (m_axis_tready),
        .i_prime_data  (m_axis_tdata),
        .i_prime_last  (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_pending     (pending_primes)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Gap lengths: usually none, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 30);
    endfunction

    // Limits are mostly small, since a pass walks every entry up to the limit;
    // a few reach the top of the range and beyond it, where the block
    // saturates, so that every bit of the field is exercised.
    function automatic logic [W_VAL-1:0] pick_limit();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return W_VAL'($urandom_range(0, 40));
        else if (r < 82)
            return W_VAL'($urandom_range(41, 200));
        else if (r < 94)
            return W_VAL'($urandom_range(201, 256));
        else
            return W_VAL'($urandom_range(257, 511));
    endfunction

    // Back-pressure on the prime stream, changed only at the falling edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (rx_hold > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold       <= rx_hold - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if (!rx_steady)
                rx_hold <= pick_gap();
        end
    end

    // Offers one limit word, after an optional gap, and holds it until the
    // block takes it. Returns just after the accepting edge, so the next call
    // can keep tvalid high for a back-to-back word.
    task automatic send_limit(input logic [W_VAL-1:0] limit);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {7'b0, W_VAL'($urandom_range(0, 511))};
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, limit};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    initial begin
        // Limits below two, the first few primes, squares of primes where the
        // outer loop just runs, the top of the range, and values above it that
        // must saturate, among them the all-ones word.
        logic [W_VAL-1:0] directed_limits[$] = '{
            9'd0, 9'd1, 9'd2, 9'd3, 9'd4, 9'd5, 9'd8, 9'd9, 9'd10, 9'd25,
            9'd49, 9'd121, 9'd169, 9'd255, 9'd256, 9'd257, 9'd289, 9'd300,
            9'd1, 9'd7, 9'd511, 9'd2
        };
        int k;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words go in back to back with a ready receiver first, then
        // six of them again, picked at random, with gaps on both sides.
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        foreach (directed_limits[k])
            send_limit(directed_limits[k]);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        for (k = 0; k < 6; k++)
            send_limit(directed_limits[$urandom_range(0, directed_limits.size() - 1)]);

        // Random limits in three stretches: gaps on both sides, then no gaps
        // at all, then gaps on the receiver only.
        for (k = 0; k < RANDOM_WORDS; k++) begin
            if (k == RANDOM_WORDS * 2 / 5) begin
                tx_steady = 1'b1;
                rx_steady = 1'b1;
            end else if (k == RANDOM_WORDS * 3 / 5) begin
                rx_steady = 1'b0;
            end
            send_limit(pick_limit());
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        tx_steady = 1'b0;

        while (pending_primes != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_primes == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
